// File: hdl/hds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hds_pkg
// Shared constants, register indexes and record types of the heat diffusion
// stencil core.
// ----------------------------------------------------------------------------
package hds_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int FIFO_DEPTH = 8;

  localparam int DATA_W      = 32;
  localparam int COEF_W      = 17;
  localparam int SIZE_W      = 11;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 17;
  localparam int OUT_TDATA_W = 56;

  localparam int COEF_RESET = 16384;
  localparam int SIZE_RESET = 1024;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COEF_X     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_ROWS = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_COLS = 4'd3;

  // Position and frame marker of one interior point.
  typedef struct packed {
    logic [SIZE_W-1:0] row;
    logic [SIZE_W-1:0] col;
    logic              last;
  } meta_t;

  // One finished result.
  typedef struct packed {
    logic [SIZE_W-1:0] col;
    logic [SIZE_W-1:0] row;
    logic [DATA_W-1:0] value;
    logic              last;
  } result_t;

endpackage

// File: hdl/hds_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hds_line_store
// Two row buffers selected by row parity. Each enabled cycle one buffer is read at
// the current column (north) and the other at the next column (east).
// ----------------------------------------------------------------------------
module hds_line_store #(
  parameter int MaxCols = hds_pkg::MAX_COLS
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic                            parity,
  input  logic [$clog2(MaxCols+2)-1:0]    col,
  input  logic [hds_pkg::DATA_W-1:0]      wr_data,
  output logic [hds_pkg::DATA_W-1:0]      north_q,
  output logic [hds_pkg::DATA_W-1:0]      east_q,
  output logic [hds_pkg::DATA_W-1:0]      col0_q
);

  localparam int Depth = MaxCols + 2;
  localparam int CW    = $clog2(Depth);

  logic [hds_pkg::DATA_W-1:0] older_mem [Depth];
  logic [hds_pkg::DATA_W-1:0] newer_mem [Depth];

  logic [hds_pkg::DATA_W-1:0] older_rd_r;
  logic [hds_pkg::DATA_W-1:0] newer_rd_r;
  logic [hds_pkg::DATA_W-1:0] col0_older_r;
  logic [hds_pkg::DATA_W-1:0] col0_newer_r;
  logic [hds_pkg::DATA_W-1:0] col0_q_r;
  logic                       parity_q_r;

  logic [CW:0]   east_wide;
  logic [CW-1:0] east_addr;
  logic [CW-1:0] older_addr;
  logic [CW-1:0] newer_addr;

  // The east address past the last entry is only used on a row-ending
  // sample, whose window value is discarded.
  always_comb begin
    east_wide  = {1'b0, col} + {{CW{1'b0}}, 1'b1};
    east_addr  = (east_wide >= (CW+1)'(Depth)) ? '0 : east_wide[CW-1:0];
    older_addr = parity ? east_addr : col;
    newer_addr = parity ? col : east_addr;
  end

  // Read-first: a read and a write of the same entry return the old word.
  always_ff @(posedge clk) begin
    if (en) begin
      older_rd_r <= older_mem[older_addr];
      newer_rd_r <= newer_mem[newer_addr];
      if (!parity) begin
        older_mem[col] <= wr_data;
      end else begin
        newer_mem[col] <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      parity_q_r <= parity;
      col0_q_r   <= parity ? col0_older_r : col0_newer_r;
      if (col == '0) begin
        if (!parity) begin
          col0_older_r <= wr_data;
        end else begin
          col0_newer_r <= wr_data;
        end
      end
    end
  end

  assign north_q = parity_q_r ? newer_rd_r : older_rd_r;
  assign east_q  = parity_q_r ? older_rd_r : newer_rd_r;
  assign col0_q  = col0_q_r;

endmodule

// File: hdl/hds_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hds_update
// Stencil arithmetic: second differences, weighted products, then sum and
// saturation to 32 bits.
// ----------------------------------------------------------------------------
module hds_update (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic signed [hds_pkg::DATA_W-1:0]  north,
  input  logic signed [hds_pkg::DATA_W-1:0]  south,
  input  logic signed [hds_pkg::DATA_W-1:0]  west,
  input  logic signed [hds_pkg::DATA_W-1:0]  east,
  input  logic signed [hds_pkg::DATA_W-1:0]  centre,
  input  hds_pkg::meta_t                     meta,
  input  logic [hds_pkg::COEF_W-1:0]         coef_x,
  input  logic [hds_pkg::COEF_W-1:0]         coef_y,
  output logic                               res_valid,
  output hds_pkg::result_t                   res
);

  localparam logic signed [38:0] SatMax = 39'sd2147483647;
  localparam logic signed [38:0] SatMin = -39'sd2147483648;

  logic                     a_valid_r;
  logic signed [34:0]       a_dx_r;
  logic signed [34:0]       a_dy_r;
  logic signed [31:0]       a_centre_r;
  hds_pkg::meta_t           a_meta_r;
  logic signed [34:0]       dx_nxt;
  logic signed [34:0]       dy_nxt;

  logic                     b_valid_r;
  logic signed [52:0]       b_px_r;
  logic signed [52:0]       b_py_r;
  logic signed [31:0]       b_centre_r;
  hds_pkg::meta_t           b_meta_r;
  logic signed [17:0]       cx_s;
  logic signed [17:0]       cy_s;

  logic signed [36:0]       tx;
  logic signed [36:0]       ty;
  logic signed [38:0]       sum;
  logic [31:0]              sat;

  always_comb begin
    dx_nxt = $signed({{3{north[31]}}, north}) + $signed({{3{south[31]}}, south})
           - $signed({{2{centre[31]}}, centre, 1'b0});
    dy_nxt = $signed({{3{east[31]}}, east}) + $signed({{3{west[31]}}, west})
           - $signed({{2{centre[31]}}, centre, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
    end
  end

  assign cx_s = $signed({1'b0, coef_x});
  assign cy_s = $signed({1'b0, coef_y});

  always_ff @(posedge clk) begin
    a_dx_r     <= dx_nxt;
    a_dy_r     <= dy_nxt;
    a_centre_r <= centre;
    a_meta_r   <= meta;
    b_px_r     <= cx_s * a_dx_r;
    b_py_r     <= cy_s * a_dy_r;
    b_centre_r <= a_centre_r;
    b_meta_r   <= a_meta_r;
  end

  // Dropping the fraction bits of a two's complement product floors it.
  always_comb begin
    tx  = b_px_r[52:16];
    ty  = b_py_r[52:16];
    sum = $signed({{7{b_centre_r[31]}}, b_centre_r}) + $signed({{2{tx[36]}}, tx})
        + $signed({{2{ty[36]}}, ty});
    if (sum > SatMax) begin
      sat = 32'h7FFF_FFFF;
    end else if (sum < SatMin) begin
      sat = 32'h8000_0000;
    end else begin
      sat = sum[31:0];
    end
  end

  assign res_valid = b_valid_r;
  always_comb begin
    res.value = sat;
    res.row   = b_meta_r.row;
    res.col   = b_meta_r.col;
    res.last  = b_meta_r.last;
  end

endmodule

// File: hdl/hds_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hds_out_fifo
// Small result queue that decouples the fixed-latency pipeline from output
// backpressure.
// ----------------------------------------------------------------------------
module hds_out_fifo #(
  parameter int Depth = hds_pkg::FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  hds_pkg::result_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output hds_pkg::result_t pop_data
);

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int NW = $clog2(Depth + 1);

  hds_pkg::result_t mem_r [Depth];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [NW-1:0]    count_r;
  logic             pop;

  assign pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + NW'(push) - NW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

endmodule

// File: hdl/heat_diffusion_stencil_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heat_diffusion_stencil_core
// Path: an accepted southern sample passes the read stage, the arithmetic
//   stages and the output queue before its result is offered.
// Throughput: one sample per cycle; the rate is bounded only by the credit
//   count over the output queue (FifoDepth results reserved at a time).
// Reset: synchronous, active low; clears position, registers and queue. The
//   row buffers are not cleared and hold undefined data until written.
// ----------------------------------------------------------------------------
module heat_diffusion_stencil_core #(
  parameter int MaxCols   = hds_pkg::MAX_COLS,
  parameter int MaxRows   = hds_pkg::MAX_ROWS,
  parameter int FifoDepth = hds_pkg::FIFO_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream. tdata: sample[31:0].
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [hds_pkg::DATA_W-1:0]          in_tdata,
  // Result stream. tdata: new_value[31:0], out_row[42:32], out_col[53:43],
  // zero padding[55:54]. tlast marks the final interior point.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [hds_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tlast,
  // Configuration write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hds_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hds_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int RW = $clog2(MaxRows + 2);
  localparam int CW = $clog2(MaxCols + 2);
  localparam int KW = $clog2(FifoDepth + 1);
  localparam int RowsReset = (hds_pkg::SIZE_RESET < MaxRows) ? hds_pkg::SIZE_RESET : MaxRows;
  localparam int ColsReset = (hds_pkg::SIZE_RESET < MaxCols) ? hds_pkg::SIZE_RESET : MaxCols;

  // --------------------------------------------------------------------------
  // Configuration. Sizes are clamped into 1..Max when written, so the
  // datapath only ever sees legal grid dimensions.
  // --------------------------------------------------------------------------
  logic [hds_pkg::COEF_W-1:0] coef_x_r;
  logic [hds_pkg::COEF_W-1:0] coef_y_r;
  logic [RW-1:0]              rows_r;
  logic [CW-1:0]              cols_r;
  logic [RW-1:0]              rows_nxt;
  logic [CW-1:0]              cols_nxt;
  logic [hds_pkg::SIZE_W-1:0] size_wr;
  logic                       cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign size_wr   = cfg_data[hds_pkg::SIZE_W-1:0];

  always_comb begin
    if (size_wr == '0) begin
      rows_nxt = RW'(1);
    end else if (int'(size_wr) > MaxRows) begin
      rows_nxt = RW'(MaxRows);
    end else begin
      rows_nxt = RW'(size_wr);
    end
    if (size_wr == '0) begin
      cols_nxt = CW'(1);
    end else if (int'(size_wr) > MaxCols) begin
      cols_nxt = CW'(MaxCols);
    end else begin
      cols_nxt = CW'(size_wr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_x_r <= hds_pkg::COEF_W'(hds_pkg::COEF_RESET);
      coef_y_r <= hds_pkg::COEF_W'(hds_pkg::COEF_RESET);
      rows_r   <= RW'(RowsReset);
      cols_r   <= CW'(ColsReset);
    end else if (cfg_wr) begin
      unique case (cfg_index)
        hds_pkg::REG_COEF_X:     coef_x_r <= cfg_data;
        hds_pkg::REG_COEF_Y:     coef_y_r <= cfg_data;
        hds_pkg::REG_INNER_ROWS: rows_r   <= rows_nxt;
        hds_pkg::REG_INNER_COLS: cols_r   <= cols_nxt;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Raster position of the next sample and classification of this one.
  // --------------------------------------------------------------------------
  logic [RW-1:0] row_r;
  logic [CW-1:0] col_r;
  logic [RW-1:0] rows_p1;
  logic [CW-1:0] cols_p1;
  logic          in_acc;
  logic          interior;
  logic          last_pt;
  logic [RW-1:0] row_m1;

  assign in_acc  = in_tvalid && in_tready;
  assign rows_p1 = rows_r + 1'b1;
  assign cols_p1 = cols_r + 1'b1;
  assign row_m1  = row_r - 1'b1;

  always_comb begin
    interior = (row_r >= RW'(2)) && (row_r <= rows_p1) &&
               (col_r != '0) && (col_r <= cols_r);
    last_pt  = (row_r == rows_p1) && (col_r == cols_r);
  end

  // A column position at or past the right ghost column ends the row; a row
  // position at or past the bottom ghost row ends the grid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (in_acc) begin
      if (col_r >= cols_p1) begin
        col_r <= '0;
        row_r <= (row_r >= rows_p1) ? '0 : row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Row buffers. The buffer of the current row parity holds the row two
  // above the sample (north); the other one holds the row just above.
  // --------------------------------------------------------------------------
  logic [hds_pkg::DATA_W-1:0] north_q;
  logic [hds_pkg::DATA_W-1:0] east_q;
  logic [hds_pkg::DATA_W-1:0] col0_q;

  hds_line_store #(
    .MaxCols (MaxCols)
  ) u_line_store (
    .clk     (clk),
    .en      (in_acc),
    .parity  (row_r[0]),
    .col     (col_r),
    .wr_data (in_tdata),
    .north_q (north_q),
    .east_q  (east_q),
    .col0_q  (col0_q)
  );

  // --------------------------------------------------------------------------
  // Read stage: the sample waits here while the buffers return data. A
  // two-word window over the row above follows the east reads, so west and
  // centre need no extra read ports.
  // --------------------------------------------------------------------------
  logic                       s1_valid_r;
  logic                       s1_interior_r;
  logic                       s1_col0_r;
  logic [hds_pkg::DATA_W-1:0] s1_sample_r;
  hds_pkg::meta_t             s1_meta_r;
  logic [hds_pkg::DATA_W-1:0] win_w_r;
  logic [hds_pkg::DATA_W-1:0] win_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      s1_interior_r <= 1'b0;
    end else begin
      s1_valid_r    <= in_acc;
      s1_interior_r <= in_acc && interior;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col0_r      <= (col_r == '0);
      s1_sample_r    <= in_tdata;
      s1_meta_r.row  <= hds_pkg::SIZE_W'(row_m1);
      s1_meta_r.col  <= hds_pkg::SIZE_W'(col_r);
      s1_meta_r.last <= last_pt;
    end
    if (s1_valid_r) begin
      win_w_r <= s1_col0_r ? col0_q : win_c_r;
      win_c_r <= east_q;
    end
  end

  // --------------------------------------------------------------------------
  // Arithmetic pipeline and result queue.
  // --------------------------------------------------------------------------
  logic             res_valid;
  hds_pkg::result_t res;
  hds_pkg::result_t head;

  hds_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_interior_r),
    .north     ($signed(north_q)),
    .south     ($signed(s1_sample_r)),
    .west      ($signed(win_w_r)),
    .east      ($signed(east_q)),
    .centre    ($signed(win_c_r)),
    .meta      (s1_meta_r),
    .coef_x    (coef_x_r),
    .coef_y    (coef_y_r),
    .res_valid (res_valid),
    .res       (res)
  );

  hds_out_fifo #(
    .Depth (FifoDepth)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (head)
  );

  assign out_tdata = {2'b00, head.col, head.row, head.value};
  assign out_tlast = head.last;

  // --------------------------------------------------------------------------
  // Credits: every accepted interior sample reserves one queue entry until
  // its result leaves, so the fixed-latency pipeline never overruns the
  // queue. Ready comes from a register and never from out_tready.
  // --------------------------------------------------------------------------
  logic [KW-1:0] credit_r;
  logic          reserve;
  logic          release_slot;

  assign reserve      = in_acc && interior;
  assign release_slot = out_tvalid && out_tready;
  assign in_tready    = (credit_r < KW'(FifoDepth));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_r + KW'(reserve) - KW'(release_slot);
    end
  end

`ifndef ASSERT_OFF
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= KW'(FifoDepth))
    else $error("credit count exceeds queue depth");

  a_result_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> credit_r != '0)
    else $error("result offered without a reserved credit");

  a_reserve_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (reserve && !release_slot) |=> credit_r == $past(credit_r) + 1'b1)
    else $error("credit not taken for an interior sample");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= CW'(MaxCols + 1))
    else $error("column position beyond the row buffers");

  a_pipe_to_queue: assert property (@(posedge clk) disable iff (!rst_n)
    s1_interior_r |=> ##1 res_valid)
    else $error("interior sample lost in the arithmetic pipeline");
`endif

endmodule

// File: verif/heat_diffusion_stencil_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heat_diffusion_stencil_core_test
// Self-checking bench for the five-point heat stencil core. Grids are
// streamed in raster order with random gaps on the sample side and random
// back-pressure on the result side. A local stencil predictor follows every
// accepted sample, and each result request is checked field by field against
// the oldest predicted interior point.
// ----------------------------------------------------------------------------
module heat_diffusion_stencil_core_test;

  localparam int LIMIT_CYCLES = 500000;
  // Drain past the pipeline latency before any register write or the end of
  // the run, since ghost samples may still be in flight.
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 650;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [hds_pkg::DATA_W-1:0]      in_tdata   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [hds_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tlast;
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  logic [hds_pkg::CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [hds_pkg::CFG_DATA_W-1:0]  cfg_data   = '0;

  heat_diffusion_stencil_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow of the configuration registers, updated on each accepted write.
  logic [hds_pkg::COEF_W-1:0] coef_x_q     = hds_pkg::COEF_W'(hds_pkg::COEF_RESET);
  logic [hds_pkg::COEF_W-1:0] coef_y_q     = hds_pkg::COEF_W'(hds_pkg::COEF_RESET);
  logic [hds_pkg::SIZE_W-1:0] inner_rows_q = hds_pkg::SIZE_W'(hds_pkg::SIZE_RESET);
  logic [hds_pkg::SIZE_W-1:0] inner_cols_q = hds_pkg::SIZE_W'(hds_pkg::SIZE_RESET);

  // Predictor state: the two previous grid rows and the raster position of
  // the next sample. Even grid rows land in even_row, odd ones in odd_row.
  logic [hds_pkg::DATA_W-1:0] even_row [0:hds_pkg::MAX_COLS+1];
  logic [hds_pkg::DATA_W-1:0] odd_row  [0:hds_pkg::MAX_COLS+1];
  logic [hds_pkg::SIZE_W-1:0] row_pos = '0;
  logic [hds_pkg::SIZE_W-1:0] col_pos = '0;

  logic [hds_pkg::DATA_W-1:0] sample_backlog [$];
  hds_pkg::result_t           expected_points [$];

  int  mismatches  = 0;
  int  cycle_count = 0;
  int  send_gap    = 0;
  int  ready_gap   = 0;
  int  hold_left   = 0;
  bit  hold_taken  = 1'b0;
  bit  hold_ask    = 1'b0;
  bit  no_idle     = 1'b0;

  // Sizes of zero act as one, sizes past the given limit act as that limit.
  function automatic int clamp_dim(logic [hds_pkg::SIZE_W-1:0] v, int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return int'(v);
  endfunction

  // Q1.16 weight times a difference, fraction dropped toward minus infinity.
  function automatic longint weigh(logic [hds_pkg::COEF_W-1:0] k, longint diff);
    longint kk;
    kk = longint'(k);
    return (kk * diff) >>> 16;
  endfunction

  // Follow one accepted sample through the stencil. A sample in an interior
  // column of rows 2..rows+1 completes the point directly above it.
  function automatic void stencil_step(logic [hds_pkg::DATA_W-1:0] s);
    int               rows_e;
    int               cols_e;
    logic [31:0]      north;
    logic [31:0]      centre;
    logic [31:0]      west;
    logic [31:0]      east;
    longint           nv, cv, wv, ev, sv, v;
    hds_pkg::result_t pt;
    rows_e = clamp_dim(inner_rows_q, hds_pkg::MAX_ROWS);
    cols_e = clamp_dim(inner_cols_q, hds_pkg::MAX_COLS);
    if (row_pos >= 2 && row_pos <= rows_e + 1 && col_pos >= 1 && col_pos <= cols_e) begin
      if (row_pos[0]) begin
        north  = odd_row[col_pos];
        centre = even_row[col_pos];
        west   = even_row[col_pos - 1];
        east   = even_row[col_pos + 1];
      end else begin
        north  = even_row[col_pos];
        centre = odd_row[col_pos];
        west   = odd_row[col_pos - 1];
        east   = odd_row[col_pos + 1];
      end
      nv = $signed(north);
      cv = $signed(centre);
      wv = $signed(west);
      ev = $signed(east);
      sv = $signed(s);
      v  = cv + weigh(coef_x_q, nv + sv - 2 * cv) + weigh(coef_y_q, ev + wv - 2 * cv);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      pt.value = v[31:0];
      pt.row   = row_pos - 1'b1;
      pt.col   = col_pos;
      pt.last  = (row_pos == rows_e + 1 && col_pos == cols_e);
      expected_points.push_back(pt);
    end
    if (col_pos <= hds_pkg::MAX_COLS + 1) begin
      if (row_pos[0]) odd_row[col_pos] = s;
      else even_row[col_pos] = s;
    end
    if (col_pos >= cols_e + 1) begin
      col_pos = '0;
      row_pos = (row_pos >= rows_e + 1) ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endfunction

  // Samples still needed before the raster position wraps to a fresh grid,
  // given the sizes currently in force.
  function automatic int samples_to_grid_end();
    int r, c, n, rows_e, cols_e;
    rows_e = clamp_dim(inner_rows_q, hds_pkg::MAX_ROWS);
    cols_e = clamp_dim(inner_cols_q, hds_pkg::MAX_COLS);
    r = int'(row_pos);
    c = int'(col_pos);
    n = 0;
    do begin
      n++;
      if (c >= cols_e + 1) begin
        c = 0;
        r = (r >= rows_e + 1) ? 0 : r + 1;
      end else begin
        c++;
      end
    end while (r != 0 || c != 0);
    return n;
  endfunction

  // Small values half the time so the arithmetic stays in range, with full-scale
  // values and both rails mixed in to reach saturation.
  function automatic logic [hds_pkg::DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom();
      default: return $urandom_range(0, 4194303) - 2097152;
    endcase
  endfunction

  function automatic logic [hds_pkg::COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 17'd65536;
      default: return hds_pkg::COEF_W'($urandom_range(0, 131071));
    endcase
  endfunction

  function automatic logic [hds_pkg::SIZE_W-1:0] pick_size();
    if ($urandom_range(0, 7) == 0) return '0;
    return hds_pkg::SIZE_W'($urandom_range(1, 7));
  endfunction

  task automatic push_samples(int n);
    repeat (n) sample_backlog.push_back(pick_sample());
  endtask

  // A single-point grid: the interior centre surrounded by one rim value.
  task automatic push_cross(logic [hds_pkg::DATA_W-1:0] centre,
                            logic [hds_pkg::DATA_W-1:0] rim);
    for (int i = 0; i < 9; i++) sample_backlog.push_back(i == 4 ? centre : rim);
  endtask

  // One configuration request; the shadow follows once it is taken. The
  // channel drops for a cycle so back-to-back writes stay separate steps.
  task automatic write_reg(logic [hds_pkg::CFG_IDX_W-1:0] idx,
                           logic [hds_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      hds_pkg::REG_COEF_X:     coef_x_q     = val;
      hds_pkg::REG_COEF_Y:     coef_y_q     = val;
      hds_pkg::REG_INNER_ROWS: inner_rows_q = val[hds_pkg::SIZE_W-1:0];
      hds_pkg::REG_INNER_COLS: inner_cols_q = val[hds_pkg::SIZE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Wait until every sample is taken and every predicted point has come out,
  // then let the pipeline drain.
  task automatic settle();
    while (sample_backlog.size() != 0 || in_tvalid || expected_points.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sample side: holds a request until it is taken, then either offers the
  // next backlog entry or, unless no_idle is set, inserts a random idle burst.
  always @(posedge clk) begin : sample_driver
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap  <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (send_gap != 0) begin
        in_tvalid <= 1'b0;
        send_gap  <= send_gap - 1;
      end else if (sample_backlog.size() != 0) begin
        if (!no_idle && $urandom_range(0, 9) == 0) begin
          in_tvalid <= 1'b0;
          send_gap  <= $urandom_range(0, 3);
        end else begin
          in_tvalid <= 1'b1;
          in_tdata  <= sample_backlog.pop_front();
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // The long hold-off is counted here so the ready side only has to look at
  // whether it is still running.
  always @(posedge clk) begin : hold_counter
    if (!rst_n) begin
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (hold_ask && !hold_taken) begin
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result back-pressure: the long hold-off, else random stalls unless no_idle.
  always @(posedge clk) begin : result_ready
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_gap  <= 0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
    end else if (no_idle) begin
      out_tready <= 1'b1;
    end else if (ready_gap != 0) begin
      out_tready <= 1'b0;
      ready_gap  <= ready_gap - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_tready <= 1'b0;
      ready_gap  <= $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Results are checked before the same edge's sample is predicted, so a
  // point can never be matched against an expectation it could not yet have.
  always @(posedge clk) begin : scoreboard
    hds_pkg::result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_points.size() == 0) begin
          $error("unexpected point row %0d col %0d value %0d",
                 out_tdata[42:32], out_tdata[53:43], $signed(out_tdata[31:0]));
          mismatches++;
        end else begin
          want = expected_points.pop_front();
          if (out_tdata[31:0] !== want.value) begin
            $error("new_value: expected %0d, got %0d",
                   $signed(want.value), $signed(out_tdata[31:0]));
            mismatches++;
          end
          if (out_tdata[42:32] !== want.row) begin
            $error("out_row: expected %0d, got %0d", want.row, out_tdata[42:32]);
            mismatches++;
          end
          if (out_tdata[53:43] !== want.col) begin
            $error("out_col: expected %0d, got %0d", want.col, out_tdata[53:43]);
            mismatches++;
          end
          if (out_tlast !== want.last) begin
            $error("last_point: expected %0d, got %0d", want.last, out_tlast);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) stencil_step(in_tdata);
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    logic [hds_pkg::DATA_W-1:0] ramp_grid [9];
    int n;
    int k;
    int phase;
    int random_items;
    ramp_grid = '{32'h0000_0000, 32'h0001_86A0, 32'hFFFF_0000,
                  32'hFFFF_0000, 32'h0003_0000, 32'h0001_0000,
                  32'h7FFF_FFFF, 32'hFFFE_0000, 32'h8000_0000};
    phase = 0;
    random_items = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    settle();

    // Directed: single-point grids. The first keeps the reset coefficients;
    // the next two use the largest weights and drive the sum into each rail.
    write_reg(hds_pkg::REG_INNER_ROWS, 17'd1);
    write_reg(hds_pkg::REG_INNER_COLS, 17'd1);
    foreach (ramp_grid[i]) sample_backlog.push_back(ramp_grid[i]);
    settle();
    write_reg(hds_pkg::REG_COEF_X, '1);
    write_reg(hds_pkg::REG_COEF_Y, '1);
    push_cross(32'h8000_0000, 32'h7FFF_FFFF);
    push_cross(32'h7FFF_FFFF, 32'h8000_0000);
    settle();

    // Oversized and zero sizes. Zero rows act as one and a width past the
    // buffers acts as the buffer width, so the first row ends at the right
    // ghost column of a full-width row. The columns are then narrowed part
    // way through the next row and the grid finishes small.
    write_reg(hds_pkg::REG_COEF_X, pick_coef());
    write_reg(hds_pkg::REG_COEF_Y, pick_coef());
    write_reg(hds_pkg::REG_INNER_ROWS, 17'd0);
    write_reg(hds_pkg::REG_INNER_COLS, 17'd2047);
    push_samples(hds_pkg::MAX_COLS + 6);
    settle();
    write_reg(hds_pkg::REG_INNER_COLS, 17'd2);
    push_samples(samples_to_grid_end());
    settle();

    // A height past the maximum with zero columns, cut short after a few
    // rows by shrinking the row count.
    write_reg(hds_pkg::REG_INNER_ROWS, 17'd1500);
    write_reg(hds_pkg::REG_INNER_COLS, 17'd0);
    push_samples(12);
    settle();
    write_reg(hds_pkg::REG_INNER_ROWS, 17'd2);
    push_samples(samples_to_grid_end());
    settle();

    // Random phases. The first is sized so the long result hold-off fills the
    // output queue and stalls the sample side. Some phases stop part way
    // through a grid, then shrink or grow the rows, narrow the columns and
    // finish the grid under the new sizes.
    while (random_items < RANDOM_ITEMS) begin
      if (random_items >= RANDOM_ITEMS - 200) no_idle = 1'b1;
      write_reg(hds_pkg::REG_COEF_X, pick_coef());
      write_reg(hds_pkg::REG_COEF_Y, pick_coef());
      write_reg(hds_pkg::REG_INNER_ROWS,
                phase == 0 ? 17'd8 : hds_pkg::CFG_DATA_W'(pick_size()));
      write_reg(hds_pkg::REG_INNER_COLS,
                phase == 0 ? 17'd12 : hds_pkg::CFG_DATA_W'(pick_size()));
      n = samples_to_grid_end();
      if (phase == 0) hold_ask = 1'b1;
      if (phase != 0 && $urandom_range(0, 2) == 0) begin
        k = $urandom_range(1, n - 1);
        push_samples(k);
        settle();
        write_reg(hds_pkg::REG_INNER_ROWS, hds_pkg::CFG_DATA_W'(pick_size()));
        write_reg(hds_pkg::REG_INNER_COLS, hds_pkg::CFG_DATA_W'(
                  $urandom_range(0, clamp_dim(inner_cols_q, hds_pkg::MAX_COLS))));
        if ($urandom_range(0, 1) == 0) write_reg(hds_pkg::REG_COEF_X, pick_coef());
        n = samples_to_grid_end();
        push_samples(n);
        random_items += k + n;
      end else begin
        n = n * $urandom_range(1, 3);
        push_samples(n);
        random_items += n;
      end
      settle();
      phase++;
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: heat_diffusion_stencil_core.f
hdl/hds_pkg.sv
hdl/hds_line_store.sv
hdl/hds_update.sv
hdl/hds_out_fifo.sv
hdl/heat_diffusion_stencil_core.sv
verif/heat_diffusion_stencil_core_test.sv
